>>> sv/binary_min_heap_queue_unit_assert.svh
// ---------------------------------------------------------------------------
// binary min-heap queue assertion macros
// clocked assertion wrappers used by the heap queue rtl
// ---------------------------------------------------------------------------
`ifndef BINARY_MIN_HEAP_QUEUE_UNIT_ASSERT_SVH
`define BINARY_MIN_HEAP_QUEUE_UNIT_ASSERT_SVH

// property checked on every clock edge outside reset
`define BMHQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked on every clock edge outside reset
`define BMHQ_ASSERT_IMPL(lbl, pre, post, msg) \
  `BMHQ_ASSERT(lbl, (pre) |-> (post), msg)

`endif

>>> sv/bmhq_pkg.sv
// ---------------------------------------------------------------------------
// bmhq_pkg
// types and constants of the binary min-heap priority queue
// ---------------------------------------------------------------------------
package bmhq_pkg;

  localparam int unsigned HEAP_DEPTH = 256;
  localparam int unsigned ADDR_W     = $clog2(HEAP_DEPTH);
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned PAY_W      = 32;
  localparam int unsigned CNT_OUT_W  = 8;

  localparam logic [ADDR_W-1:0] HEAP_MAX = ADDR_W'(HEAP_DEPTH - 1);

  typedef enum logic {
    CMD_INSERT  = 1'b0,
    CMD_EXTRACT = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic signed [PAY_W-1:0] payload;
  } heap_entry_t;

  typedef struct packed {
    cmd_e                    command;
    logic signed [KEY_W-1:0] key;
    logic signed [PAY_W-1:0] payload;
  } in_word_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] top_key;
    logic signed [PAY_W-1:0] top_payload;
    logic                    top_valid;
    logic [CNT_OUT_W-1:0]    entry_count;
    status_e                 status;
  } out_word_t;

endpackage

>>> sv/binary_min_heap_queue_unit.sv
// ---------------------------------------------------------------------------
// binary_min_heap_queue_unit
// one-based binary min-heap of key/payload pairs held in a single-port
// synchronous memory, sifted one level at a time by a small sequencer
// ---------------------------------------------------------------------------
//  channel  direction  handshake                 word
//  in       input      in_valid_i / in_stall_o   bmhq_pkg::in_word_t
//  out      output     out_valid_o / out_stall_i bmhq_pkg::out_word_t
//
//  an insert climbs from the new last slot, moving each larger parent down one level at a time;
//  an extract moves the last entry to the root and descends, reading the left then the right child
//  a rejected word only reads the root; the next word is taken in the cycle after the load
//  the memory port, one read or write per cycle, sets the pace; a full output delays the load
//  reset clears the count and control; memory contents are not cleared
//  a new word is taken while the last result waits in the output register
module binary_min_heap_queue_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bmhq_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bmhq_pkg::out_word_t out_data_o
);
  import bmhq_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_UP_CHK  = 4'd1;
  localparam logic [3:0] S_UP_CMP  = 4'd2;
  localparam logic [3:0] S_DN_LAST = 4'd3;
  localparam logic [3:0] S_DN_CHK  = 4'd4;
  localparam logic [3:0] S_DN_RL   = 4'd5;
  localparam logic [3:0] S_DN_RR   = 4'd6;
  localparam logic [3:0] S_ROOT_RD = 4'd7;
  localparam logic [3:0] S_FIN     = 4'd8;

  localparam logic [ADDR_W-1:0] ROOT_ADDR = ADDR_W'(1);

  logic [3:0]        state_q, state_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  heap_entry_t       elem_q, elem_d;
  heap_entry_t       best_q, best_d;
  logic              lbest_q, lbest_d;
  status_e           status_q, status_d;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_q, out_d;

  heap_entry_t       mem [HEAP_DEPTH];
  heap_entry_t       rdata_q;
  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  heap_entry_t       wr_data;

  logic [ADDR_W:0]   left_idx, right_idx;
  logic              right_ok;
  logic              out_take;
  logic signed [KEY_W-1:0] cand_key;

  assign left_idx  = {pos_q, 1'b0};
  assign right_idx = {pos_q, 1'b1};
  assign right_ok  = right_idx <= {1'b0, cnt_q};
  assign out_take  = out_valid_q && !out_stall_i;
  assign cand_key  = lbest_q ? best_q.key : elem_q.key;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    elem_d      = elem_q;
    best_d      = best_q;
    lbest_d     = lbest_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = pos_q;
    wr_data     = elem_q;

    if (out_take) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          status_d = STATUS_OK;
          if (in_data_i.command == CMD_INSERT) begin
            if (cnt_q == HEAP_MAX) begin
              status_d = STATUS_FULL;
              state_d  = S_ROOT_RD;
            end else begin
              cnt_d          = cnt_q + 1'b1;
              pos_d          = cnt_q + 1'b1;
              elem_d.key     = in_data_i.key;
              elem_d.payload = in_data_i.payload;
              state_d        = S_UP_CHK;
            end
          end else begin
            if (cnt_q == '0) begin
              status_d = STATUS_EMPTY;
              state_d  = S_ROOT_RD;
            end else begin
              rd_en   = 1'b1;
              rd_addr = cnt_q;
              cnt_d   = cnt_q - 1'b1;
              state_d = S_DN_LAST;
            end
          end
        end
      end
      S_UP_CHK: begin
        if (pos_q == ROOT_ADDR) begin
          wr_en   = 1'b1;
          state_d = S_ROOT_RD;
        end else begin
          rd_en   = 1'b1;
          rd_addr = pos_q >> 1;
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        wr_en = 1'b1;
        if ($signed(rdata_q.key) > $signed(elem_q.key)) begin
          wr_data = rdata_q;
          pos_d   = pos_q >> 1;
          state_d = S_UP_CHK;
        end else begin
          state_d = S_ROOT_RD;
        end
      end
      S_DN_LAST: begin
        elem_d  = rdata_q;
        pos_d   = ROOT_ADDR;
        state_d = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (left_idx > {1'b0, cnt_q}) begin
          wr_en   = 1'b1;
          state_d = S_ROOT_RD;
        end else begin
          rd_en   = 1'b1;
          rd_addr = left_idx[ADDR_W-1:0];
          state_d = S_DN_RL;
        end
      end
      S_DN_RL: begin
        if (right_ok) begin
          lbest_d = $signed(rdata_q.key) < $signed(elem_q.key);
          best_d  = rdata_q;
          rd_en   = 1'b1;
          rd_addr = right_idx[ADDR_W-1:0];
          state_d = S_DN_RR;
        end else begin
          wr_en = 1'b1;
          if ($signed(rdata_q.key) < $signed(elem_q.key)) begin
            wr_data = rdata_q;
            pos_d   = left_idx[ADDR_W-1:0];
            state_d = S_DN_CHK;
          end else begin
            state_d = S_ROOT_RD;
          end
        end
      end
      S_DN_RR: begin
        wr_en = 1'b1;
        if ($signed(rdata_q.key) < cand_key) begin
          wr_data = rdata_q;
          pos_d   = right_idx[ADDR_W-1:0];
          state_d = S_DN_CHK;
        end else if (lbest_q) begin
          wr_data = best_q;
          pos_d   = left_idx[ADDR_W-1:0];
          state_d = S_DN_CHK;
        end else begin
          state_d = S_ROOT_RD;
        end
      end
      S_ROOT_RD: begin
        rd_en   = 1'b1;
        rd_addr = ROOT_ADDR;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_take) begin
          out_valid_d       = 1'b1;
          out_d.top_valid   = cnt_q != '0;
          out_d.top_key     = (cnt_q != '0) ? rdata_q.key : '0;
          out_d.top_payload = (cnt_q != '0) ? rdata_q.payload : '0;
          out_d.entry_count = CNT_OUT_W'(cnt_q);
          out_d.status      = status_q;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    elem_q   <= elem_d;
    best_q   <= best_d;
    lbest_q  <= lbest_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `include "binary_min_heap_queue_unit_assert.svh"

  `BMHQ_ASSERT(a_cnt_range, cnt_q <= HEAP_MAX, "entry count beyond capacity")
  `BMHQ_ASSERT_IMPL(a_wr_slot, wr_en, wr_addr != '0, "write to unused slot zero")
  `BMHQ_ASSERT_IMPL(a_rd_slot, rd_en, rd_addr != '0, "read of unused slot zero")
  `BMHQ_ASSERT_IMPL(a_cnt_step, cnt_q != $past(cnt_q), $past(state_q == S_IDLE),
                    "count changed outside word acceptance")
  `BMHQ_ASSERT_IMPL(a_out_load, $rose(out_valid_o), $past(state_q == S_FIN),
                    "result loaded before operation finished")

endmodule

>>> sim/testbench.sv
// ---------------------------------------------------------------------------
// binary min-heap queue testbench
// drives insert and extract words into the heap queue through a
// valid/stall driver fed from a queue, keeps its own heap of key/payload
// pairs to predict every result word, and checks each result field by
// field in a monitor. directed words hit the extremes, ties and the empty
// case; random runs fill the heap past capacity, drain it past empty and
// mix both, under changing idle rates and one long output hold-off
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bmhq_pkg::*;

  localparam int N_ITEMS     = 1650;
  localparam int CAPACITY    = HEAP_DEPTH - 1;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 5000;
  localparam int TAIL_CYCLES = 64;
  localparam int MAX_PRINTS  = 40;

  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  typedef enum int {
    GEN_FILL,
    GEN_DRAIN,
    GEN_MIX
  } gen_mode_e;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  in_word_t    in_word   = '0;
  logic        out_stall = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  out_word_t   out_data_o;

  in_word_t    pending_words[$];
  out_word_t   result_q[$];
  int          total_words  = 0;
  int          n_taken      = 0;
  int          n_results    = 0;
  int          error_count  = 0;
  int          hold_left    = 0;
  bit          hold_done    = 1'b0;
  int          quiet_cycles = 0;
  int          gen_count    = 0;

  heap_entry_t heap_slots [HEAP_DEPTH];
  int          heap_fill = 0;

  always #6 clk_i = ~clk_i;

  binary_min_heap_queue_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_word),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  function automatic bit key_lt(logic signed [KEY_W-1:0] a, logic signed [KEY_W-1:0] b);
    return a < b;
  endfunction

  function automatic void swap_slots(int x, int y);
    heap_entry_t tmp;
    tmp           = heap_slots[x];
    heap_slots[x] = heap_slots[y];
    heap_slots[y] = tmp;
  endfunction

  function automatic out_word_t heap_apply(in_word_t w);
    out_word_t r;
    status_e   st;
    int        pos;
    int        left;
    int        best;
    bit        done;
    st = STATUS_OK;
    if (w.command == CMD_INSERT) begin
      if (heap_fill >= CAPACITY) begin
        st = STATUS_FULL;
      end else begin
        heap_fill++;
        heap_slots[heap_fill].key     = w.key;
        heap_slots[heap_fill].payload = w.payload;
        pos = heap_fill;
        while (pos > 1 && key_lt(heap_slots[pos].key, heap_slots[pos / 2].key)) begin
          swap_slots(pos, pos / 2);
          pos = pos / 2;
        end
      end
    end else begin
      if (heap_fill == 0) begin
        st = STATUS_EMPTY;
      end else begin
        heap_slots[1] = heap_slots[heap_fill];
        heap_fill--;
        pos  = 1;
        done = 1'b0;
        while (!done) begin
          left = 2 * pos;
          best = pos;
          if (left <= heap_fill) begin
            if (key_lt(heap_slots[left].key, heap_slots[best].key)) best = left;
            if (left + 1 <= heap_fill &&
                key_lt(heap_slots[left + 1].key, heap_slots[best].key)) best = left + 1;
          end
          if (best == pos) begin
            done = 1'b1;
          end else begin
            swap_slots(pos, best);
            pos = best;
          end
        end
      end
    end
    r             = '0;
    r.top_valid   = heap_fill > 0;
    r.top_key     = (heap_fill > 0) ? heap_slots[1].key : '0;
    r.top_payload = (heap_fill > 0) ? heap_slots[1].payload : '0;
    r.entry_count = CNT_OUT_W'(heap_fill);
    r.status      = st;
    return r;
  endfunction

  function automatic void push_word(cmd_e c, logic signed [KEY_W-1:0] k,
                                    logic signed [PAY_W-1:0] p);
    in_word_t w;
    w.command = c;
    w.key     = k;
    w.payload = p;
    pending_words = {pending_words, w};
    if (c == CMD_INSERT && gen_count < CAPACITY) gen_count++;
    if (c == CMD_EXTRACT && gen_count > 0) gen_count--;
  endfunction

  function automatic logic signed [KEY_W-1:0] pick_key();
    logic signed [KEY_W-1:0] k;
    case ($urandom_range(0, 9))
      0:       k = KEY_MIN;
      1:       k = KEY_MAX;
      2, 3, 4: k = $urandom_range(0, 15) - 8;
      default: k = $urandom;
    endcase
    return k;
  endfunction

  function automatic logic signed [PAY_W-1:0] pick_payload();
    logic signed [PAY_W-1:0] p;
    case ($urandom_range(0, 15))
      0:       p = KEY_MIN;
      1:       p = KEY_MAX;
      default: p = $urandom;
    endcase
    return p;
  endfunction

  function automatic int idle_pct(bit sender_side);
    int phase;
    phase = (total_words == 0) ? 0 : n_taken * 3 / total_words;
    if (phase == 0) return sender_side ? 32 : 62;
    if (phase == 1) return sender_side ? 62 : 32;
    return 0;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (error_count < MAX_PRINTS) begin
      $display("mismatch at result %0d: %s got %0h expected %0h", n_results, what, got, want);
    end
    error_count++;
  endtask

  task automatic check_result(out_word_t got, out_word_t want);
    if (got.top_key !== want.top_key)
      report_mismatch("top_key", 64'(got.top_key), 64'(want.top_key));
    if (got.top_payload !== want.top_payload)
      report_mismatch("top_payload", 64'(got.top_payload), 64'(want.top_payload));
    if (got.top_valid !== want.top_valid)
      report_mismatch("top_valid", 64'(got.top_valid), 64'(want.top_valid));
    if (got.entry_count !== want.entry_count)
      report_mismatch("entry_count", 64'(got.entry_count), 64'(want.entry_count));
    if (got.status !== want.status)
      report_mismatch("status", 64'(got.status), 64'(want.status));
  endtask

  task automatic build_words();
    gen_mode_e mode;
    int        rejects;
    int        reject_goal;
    int        mix_left;
    bit        is_insert;
    // empty extract, extremes, ties, then drain past empty
    push_word(CMD_EXTRACT, '0, '0);
    push_word(CMD_INSERT, 32'sd5, 32'sd1);
    push_word(CMD_INSERT, KEY_MAX, KEY_MAX);
    push_word(CMD_INSERT, KEY_MIN, KEY_MIN);
    push_word(CMD_INSERT, 32'sd5, 32'sd2);
    push_word(CMD_INSERT, 32'sd5, 32'sd3);
    push_word(CMD_INSERT, -32'sd1, -32'sd1);
    push_word(CMD_INSERT, '0, '0);
    push_word(CMD_INSERT, KEY_MIN, 32'sd7);
    for (int i = 0; i < 10; i++) push_word(CMD_EXTRACT, KEY_MAX, KEY_MIN);
    mode        = GEN_FILL;
    rejects     = 0;
    reject_goal = $urandom_range(1, 4);
    mix_left    = 0;
    while (pending_words.size() < N_ITEMS) begin
      case (mode)
        GEN_FILL:  is_insert = $urandom_range(0, 99) < 80;
        GEN_DRAIN: is_insert = $urandom_range(0, 99) < 20;
        default:   is_insert = $urandom_range(0, 99) < 50;
      endcase
      if (mode == GEN_FILL && is_insert && gen_count == CAPACITY) rejects++;
      if (mode == GEN_DRAIN && !is_insert && gen_count == 0) rejects++;
      push_word(is_insert ? CMD_INSERT : CMD_EXTRACT, pick_key(), pick_payload());
      if (mode == GEN_MIX) begin
        mix_left--;
        if (mix_left <= 0) mode = GEN_FILL;
      end else if (rejects >= reject_goal) begin
        rejects     = 0;
        reject_goal = $urandom_range(1, 4);
        if (mode == GEN_FILL) begin
          mode = GEN_DRAIN;
        end else begin
          mode     = GEN_MIX;
          mix_left = $urandom_range(60, 160);
        end
      end
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) begin
        result_q = {result_q, heap_apply(in_word)};
        n_taken <= n_taken + 1;
      end
      if (!in_valid || !in_stall_o) begin
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
          in_word  <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (result_q.size() == 0) begin
          report_mismatch("result with nothing pending", 64'(out_data_o.top_key), '0);
        end else begin
          check_result(out_data_o, result_q.pop_front());
        end
        n_results <= n_results + 1;
      end
      out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < idle_pct(1'b0));
    end
  end

  // long output hold-off while the sender keeps offering words
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && total_words != 0 && n_taken >= total_words * 3 / 4) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    build_words();
    total_words = pending_words.size();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (n_taken != total_words || result_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (result_q.size() != 0) report_mismatch("results missing", 64'(result_q.size()), '0);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/bmhq_pkg.sv
sv/binary_min_heap_queue_unit.sv
sim/testbench.sv
